// File: hw/rtl/tsp_pkg.sv
// tsp_pkg: shared types, widths, register indexes and the arctangent table
// for the tilt-to-servo-pulse block. No dependencies.
`default_nettype none

package tsp_pkg;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_SPAN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 2'd2;

  localparam logic [11:0] PULSE_MIN_RST   = 12'd500;
  localparam logic [11:0] PULSE_SPAN_RST  = 12'd2000;
  localparam logic [15:0] ANGLE_LIMIT_RST = 16'd34560;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 2;

  // Command codes (in_tuser)
  localparam logic CMD_ACCEL  = 1'b0;
  localparam logic CMD_TARGET = 1'b1;

  // CORDIC
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned TAB_LEN          = 24;
  localparam int unsigned TAB_IDX_W        = 5;
  localparam int unsigned ATAN_W           = 22;
  localparam int unsigned VEC_W            = 26;
  localparam logic signed [VEC_W-1:0] Z_90 = 26'sd5898240;  // 90 deg, 16 frac bits
  localparam logic signed [17:0] ANGLE_MAX = 18'sd46080;    // 180 deg, 8 frac bits

  // Sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_SQA   = 10'b00_0000_0010,
    ST_SQB   = 10'b00_0000_0100,
    ST_SQRT  = 10'b00_0000_1000,
    ST_CINIT = 10'b00_0001_0000,
    ST_CORD  = 10'b00_0010_0000,
    ST_CFIN  = 10'b00_0100_0000,
    ST_MAP   = 10'b00_1000_0000,
    ST_DIV   = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [TAB_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tilt_to_servo_pulse_top.sv
// tilt_to_servo_pulse_top: tilt angles (CORDIC atan2 + digit sqrt) or direct
// target angles mapped to two servo pulse widths. Depends on tsp_pkg.
`default_nettype none

// Usage:
//  in_*  : one request per item. in_tuser is the command (0 accelerometer
//          sample, 1 direct target angle pair); in_tdata carries the sample
//          and the targets. The block takes one request at a time; in_tready
//          is high only while the sequencer is idle.
//  out_* : one result per request, from an output register. in_tready comes
//          back while a finished result still waits on out_tready.
//  cfg_* : pulse_min, pulse_span, angle_limit; write only while idle.
// For a sample the sequencer runs two squaring states, the square root digit
// loop, two CORDIC passes (load, CORDIC_STEPS steps, finish) and two pulse
// divisions (map state, then restoring divide loop) and a hand-over state; an
// axis out of range or at the limit skips its divide loop. A target pair skips
// to the divisions. The block takes no new request until the last one has been
// handed over to the output register; the square root digit loop, the shared
// CORDIC step and the restoring divider are iterated rather than pipelined.
// Reset (synchronous, rst_n low) restores the register defaults, clears both
// held pulses to 0 and drops out_tvalid. A stalled receiver holds the result
// in the output register; the next item is then parked at its last state until
// the register frees up.

module tilt_to_servo_pulse_top #(
  parameter int unsigned CORDIC_STEPS = tsp_pkg::CORDIC_STEPS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], target_x[64:48],
  // target_y[81:65], zero fill [87:82]
  input  wire [tsp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command[0]
  input  wire [tsp_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // pulse_x[12:0], pulse_y[25:13], angle_x[42:26], angle_y[59:43], zero [63:60]
  output logic [tsp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // x_in_range[0], y_in_range[1]
  output logic [tsp_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  input  wire                              cfg_we,
  input  wire [tsp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire [tsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int unsigned CNT_W  = (STEP_W > tsp_pkg::TAB_IDX_W) ? STEP_W
                                                                  : tsp_pkg::TAB_IDX_W;
  localparam int unsigned VW     = tsp_pkg::VEC_W;

  localparam logic [CNT_W-1:0] CNT_CORD_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] CNT_SQRT_LAST = CNT_W'(23);
  localparam logic [CNT_W-1:0] CNT_DIV_LAST  = CNT_W'(11);

  // ---------------------------------------------------------------------------
  // Registers
  tsp_pkg::state_t          state_r, state_nxt;
  logic [11:0]              pmin_r, pmin_nxt;
  logic [11:0]              pspan_r, pspan_nxt;
  logic [15:0]              lim_r, lim_nxt;
  logic signed [15:0]       ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic signed [16:0]       angx_r, angx_nxt, angy_r, angy_nxt;
  logic                     pass_r, pass_nxt;
  logic                     axis_r, axis_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [31:0]              sq_r, sq_nxt;
  logic [47:0]              rad_r, rad_nxt;
  logic [24:0]              srem_r, srem_nxt;
  logic [23:0]              root_r, root_nxt;
  logic signed [VW-1:0]     cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic                     zero_r, zero_nxt;
  logic [16:0]              drem_r, drem_nxt;
  logic [11:0]              dq_r, dq_nxt;
  logic                     okx_r, okx_nxt, oky_r, oky_nxt;
  logic [12:0]              heldx_r, heldx_nxt, heldy_r, heldy_nxt;
  logic                     oval_r, oval_nxt;
  logic [tsp_pkg::OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic [tsp_pkg::OUT_TUSER_W-1:0] ouser_r, ouser_nxt;

  // ---------------------------------------------------------------------------
  // Datapath pieces
  logic signed [15:0]    mul_op;
  logic signed [31:0]    sq_prod;
  logic [26:0]           sq_t, sq_trial;
  logic signed [VW-1:0]  v_x0, v_y0;
  logic signed [VW-1:0]  c_dx, c_dy;
  logic signed [VW-1:0]  c_tab;
  logic signed [VW-1:0]  z_rnd;
  logic signed [17:0]    z_q, z_clip, z_neg;
  logic signed [16:0]    map_a;
  logic signed [17:0]    map_a18, lim18, map_apl;
  logic                  map_in, map_top;
  logic [28:0]           map_num;
  logic [17:0]           div_t, div_d;
  logic                  in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = oval_r && out_tready;

  // Shared 16x16 squarer
  assign mul_op  = (state_r == tsp_pkg::ST_SQA) ? ay_r : az_r;
  assign sq_prod = mul_op * mul_op;

  // Square root digit step
  assign sq_t     = {srem_r, rad_r[47:46]};
  assign sq_trial = {1'b0, root_r, 2'b01};

  // CORDIC pass operands: roll (ay, az), then pitch (-ax, magnitude)
  always_comb begin
    if (pass_r == 1'b0) begin
      v_y0 = VW'(ay_r) <<< 8;
      v_x0 = VW'(az_r) <<< 8;
    end else begin
      v_y0 = -(VW'(ax_r) <<< 8);
      v_x0 = VW'({1'b0, root_r});
    end
  end

  // CORDIC vectoring step (floor shifts)
  assign c_dx  = cy_r >>> cnt_r;
  assign c_dy  = cx_r >>> cnt_r;
  assign c_tab = VW'(tsp_pkg::atan_lut(cnt_r[tsp_pkg::TAB_IDX_W-1:0]));

  // Round to 8 fraction bits, clamp, negate
  assign z_rnd  = cz_r + VW'(128);
  assign z_q    = z_rnd[VW-1:8];
  assign z_clip = (z_q > tsp_pkg::ANGLE_MAX)  ? tsp_pkg::ANGLE_MAX :
                  (z_q < -tsp_pkg::ANGLE_MAX) ? -tsp_pkg::ANGLE_MAX : z_q;
  assign z_neg  = zero_r ? 18'sd0 : -z_clip;

  // Range check and numerator for the pulse map
  assign map_a   = axis_r ? angy_r : angx_r;
  assign map_a18 = 18'(map_a);
  assign lim18   = {2'b00, lim_r};
  assign map_in  = (map_a18 >= -lim18) && (map_a18 <= lim18);
  assign map_top = (map_a18 == lim18);
  assign map_apl = map_a18 + lim18;
  assign map_num = 29'(map_apl[16:0]) * 29'(pspan_r);

  // Restoring divider step, divisor 2*limit
  assign div_t = {drem_r, dq_r[11]};
  assign div_d = {1'b0, lim_r, 1'b0};

  // ---------------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pmin_nxt  = pmin_r;
    pspan_nxt = pspan_r;
    lim_nxt   = lim_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    az_nxt    = az_r;
    angx_nxt  = angx_r;
    angy_nxt  = angy_r;
    pass_nxt  = pass_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    sq_nxt    = sq_r;
    rad_nxt   = rad_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    zero_nxt  = zero_r;
    drem_nxt  = drem_r;
    dq_nxt    = dq_r;
    okx_nxt   = okx_r;
    oky_nxt   = oky_r;
    heldx_nxt = heldx_r;
    heldy_nxt = heldy_r;
    oval_nxt  = oval_r;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;

    // config writes
    if (cfg_we) begin
      case (cfg_addr)
        tsp_pkg::REG_PULSE_MIN:   pmin_nxt  = cfg_wdata[11:0];
        tsp_pkg::REG_PULSE_SPAN:  pspan_nxt = cfg_wdata[11:0];
        tsp_pkg::REG_ANGLE_LIMIT: lim_nxt   = cfg_wdata;
        default: ;
      endcase
    end

    if (out_acc) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      tsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          ax_nxt   = in_tdata[15:0];
          ay_nxt   = in_tdata[31:16];
          az_nxt   = in_tdata[47:32];
          angx_nxt = in_tdata[64:48];
          angy_nxt = in_tdata[81:65];
          axis_nxt = 1'b0;
          pass_nxt = 1'b0;
          if (in_tuser[0] == tsp_pkg::CMD_TARGET) begin
            state_nxt = tsp_pkg::ST_MAP;
          end else begin
            state_nxt = tsp_pkg::ST_SQA;
          end
        end
      end

      tsp_pkg::ST_SQA: begin
        sq_nxt    = sq_prod;
        state_nxt = tsp_pkg::ST_SQB;
      end

      tsp_pkg::ST_SQB: begin
        rad_nxt   = {sq_r + sq_prod, 16'h0000};
        srem_nxt  = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = tsp_pkg::ST_SQRT;
      end

      // one root bit per cycle
      tsp_pkg::ST_SQRT: begin
        rad_nxt = {rad_r[45:0], 2'b00};
        if (sq_t >= sq_trial) begin
          srem_nxt = 25'(sq_t - sq_trial);
          root_nxt = {root_r[22:0], 1'b1};
        end else begin
          srem_nxt = sq_t[24:0];
          root_nxt = {root_r[22:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_SQRT_LAST) begin
          state_nxt = tsp_pkg::ST_CINIT;
        end
      end

      // load vector, pre-rotate the left half-plane by 90 degrees
      tsp_pkg::ST_CINIT: begin
        zero_nxt = (v_x0 == '0) && (v_y0 == '0);
        cnt_nxt  = '0;
        if (v_x0 < 0) begin
          if (v_y0 >= 0) begin
            cx_nxt = v_y0;
            cy_nxt = -v_x0;
            cz_nxt = tsp_pkg::Z_90;
          end else begin
            cx_nxt = -v_y0;
            cy_nxt = v_x0;
            cz_nxt = -tsp_pkg::Z_90;
          end
        end else begin
          cx_nxt = v_x0;
          cy_nxt = v_y0;
          cz_nxt = '0;
        end
        state_nxt = tsp_pkg::ST_CORD;
      end

      tsp_pkg::ST_CORD: begin
        if (cy_r >= 0) begin
          cx_nxt = cx_r + c_dx;
          cy_nxt = cy_r - c_dy;
          cz_nxt = cz_r + c_tab;
        end else begin
          cx_nxt = cx_r - c_dx;
          cy_nxt = cy_r + c_dy;
          cz_nxt = cz_r - c_tab;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_CORD_LAST) begin
          state_nxt = tsp_pkg::ST_CFIN;
        end
      end

      tsp_pkg::ST_CFIN: begin
        if (pass_r == 1'b0) begin
          angx_nxt  = z_neg[16:0];
          pass_nxt  = 1'b1;
          state_nxt = tsp_pkg::ST_CINIT;
        end else begin
          angy_nxt  = z_neg[16:0];
          state_nxt = tsp_pkg::ST_MAP;
        end
      end

      // range check; top of range maps straight to min+span
      tsp_pkg::ST_MAP: begin
        drem_nxt = map_num[28:12];
        dq_nxt   = map_num[11:0];
        cnt_nxt  = '0;
        if (!map_in || map_top) begin
          if (axis_r) begin
            oky_nxt = map_in;
            if (map_in) heldy_nxt = 13'(pmin_r) + 13'(pspan_r);
            state_nxt = tsp_pkg::ST_DONE;
          end else begin
            okx_nxt = map_in;
            if (map_in) heldx_nxt = 13'(pmin_r) + 13'(pspan_r);
            axis_nxt = 1'b1;
          end
        end else begin
          state_nxt = tsp_pkg::ST_DIV;
        end
      end

      // one quotient bit per cycle
      tsp_pkg::ST_DIV: begin
        if (div_t >= div_d) begin
          drem_nxt = 17'(div_t - div_d);
          dq_nxt   = {dq_r[10:0], 1'b1};
        end else begin
          drem_nxt = div_t[16:0];
          dq_nxt   = {dq_r[10:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_DIV_LAST) begin
          if (axis_r) begin
            oky_nxt   = 1'b1;
            heldy_nxt = 13'(pmin_r) + 13'(dq_nxt);
            state_nxt = tsp_pkg::ST_DONE;
          end else begin
            okx_nxt   = 1'b1;
            heldx_nxt = 13'(pmin_r) + 13'(dq_nxt);
            axis_nxt  = 1'b1;
            state_nxt = tsp_pkg::ST_MAP;
          end
        end
      end

      // hand over to the output register once it is free
      tsp_pkg::ST_DONE: begin
        if (!oval_r || out_tready) begin
          oval_nxt  = 1'b1;
          odata_nxt = {4'b0000, angy_r, angx_r, heldy_r, heldx_r};
          ouser_nxt = {oky_r, okx_r};
          state_nxt = tsp_pkg::ST_IDLE;
        end
      end

      default: state_nxt = tsp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsp_pkg::ST_IDLE;
      pmin_r  <= tsp_pkg::PULSE_MIN_RST;
      pspan_r <= tsp_pkg::PULSE_SPAN_RST;
      lim_r   <= tsp_pkg::ANGLE_LIMIT_RST;
      heldx_r <= '0;
      heldy_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pmin_r  <= pmin_nxt;
      pspan_r <= pspan_nxt;
      lim_r   <= lim_nxt;
      heldx_r <= heldx_nxt;
      heldy_r <= heldy_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    az_r    <= az_nxt;
    angx_r  <= angx_nxt;
    angy_r  <= angy_nxt;
    pass_r  <= pass_nxt;
    axis_r  <= axis_nxt;
    cnt_r   <= cnt_nxt;
    sq_r    <= sq_nxt;
    rad_r   <= rad_nxt;
    srem_r  <= srem_nxt;
    root_r  <= root_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    zero_r  <= zero_nxt;
    drem_r  <= drem_nxt;
    dq_r    <= dq_nxt;
    okx_r   <= okx_nxt;
    oky_r   <= oky_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign in_tready  = (state_r == tsp_pkg::ST_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

`default_nettype wire

// File: hw/rtl/tsp_checker.sv
// tsp_checker: port-level assertions for tilt_to_servo_pulse_top, bound in
// below. Depends on tsp_pkg.
`default_nettype none

module tsp_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire [tsp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire [tsp_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input wire                              out_tvalid,
  input wire                              out_tready
);

  // last delivered pulses, which is what a held axis must repeat
  logic [12:0] last_px_r;
  logic [12:0] last_py_r;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_px_r <= '0;
      last_py_r <= '0;
    end else if (out_acc) begin
      last_px_r <= out_tdata[12:0];
      last_py_r <= out_tdata[25:13];
    end
  end

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request accepted while previous one still in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // out-of-range axis repeats the previous pulse
  a_hold_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_tuser[0] |-> out_tdata[12:0] == last_px_r)
    else $error("held x pulse changed");

  a_hold_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_tuser[1] |-> out_tdata[25:13] == last_py_r)
    else $error("held y pulse changed");

endmodule

bind tilt_to_servo_pulse_top tsp_checker u_tsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// File: tb/tilt_to_servo_pulse_top_tb.sv
// Self-checking testbench for tilt_to_servo_pulse_top: a queued stream driver,
// a checking monitor and an in-bench model of the tilt math and pulse mapping.
// Depends on tsp_pkg and the tilt_to_servo_pulse_top RTL.
`timescale 1ns / 100ps

module tilt_to_servo_pulse_top_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned STEPS       = tsp_pkg::CORDIC_STEPS_DEF;
  localparam int unsigned IDLE_PCT    = 36;
  localparam int unsigned END_WAIT    = 120;  // beyond the sample latency
  localparam int unsigned HOLD_START  = 4000; // inside the first random batch
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [tsp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [16:0] tx;
    logic [16:0] ty;
  } tilt_request_t;

  typedef struct packed {
    logic [12:0] pulse_x;
    logic [12:0] pulse_y;
    logic [16:0] angle_x;
    logic [16:0] angle_y;
    logic        x_ok;
    logic        y_ok;
  } pulse_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [tsp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [tsp_pkg::IN_TUSER_W-1:0]  in_tuser = '0;
  logic                            in_tvalid = 1'b0;
  wire                             in_tready;
  wire [tsp_pkg::OUT_TDATA_W-1:0]  out_tdata;
  wire [tsp_pkg::OUT_TUSER_W-1:0]  out_tuser;
  wire                             out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  tilt_to_servo_pulse_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Model state: register copies and held pulses
  logic [11:0] cur_pulse_min;
  logic [11:0] cur_pulse_span;
  logic [15:0] cur_angle_limit;
  logic [12:0] held_x;
  logic [12:0] held_y;

  tilt_request_t pending_requests_q[$];
  pulse_result_t expected_pulses_q[$];
  tilt_request_t offered_req;

  int unsigned requests_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count;
  int unsigned hold_left = 0;
  int unsigned hold_clock = 0;
  logic        tx_idle;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic longint atan_q16(input int unsigned i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      22: return 1;
      default: return 0;
    endcase
  endfunction

  // bit-pair integer square root, rounds down
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    longint unsigned rem;
    root  = 0;
    rem   = n;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // vectoring atan2(yv, xv), degrees with 8 fraction bits, clamped
  function automatic longint vector_angle(input longint yv, input longint xv);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    x = xv;
    y = yv;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: pre-rotate by a quarter turn
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(90) <<< 16;
      end else begin
        t = x; x = -y; y = t; z = -(longint'(90) <<< 16);
      end
    end
    for (int unsigned i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_q16(i);
      end else begin
        x = x - dx; y = y + dy; z = z - atan_q16(i);
      end
    end
    z = (z + 128) >>> 8;
    if (z > 46080) z = 46080;
    if (z < -46080) z = -46080;
    return z;
  endfunction

  // returns {in_range, pulse}; out of range keeps the held pulse
  function automatic logic [13:0] axis_pulse(input longint a, input logic [12:0] held);
    longint lim;
    longint span;
    longint idx;
    lim  = longint'(cur_angle_limit);
    span = longint'(cur_pulse_span);
    if (a < -lim || a > lim) return {1'b0, held};
    if (a == lim) idx = span;
    else idx = ((a + lim) * span) / (2 * lim);
    return {1'b1, 13'(longint'(cur_pulse_min) + idx)};
  endfunction

  function automatic pulse_result_t predict_pulses(input tilt_request_t req);
    pulse_result_t   res;
    longint          ax;
    longint          ay;
    longint          az;
    longint          ang_x;
    longint          ang_y;
    longint unsigned mag;
    logic [13:0]     px;
    logic [13:0]     py;
    if (req.cmd == tsp_pkg::CMD_ACCEL) begin
      ax    = $signed(req.ax);
      ay    = $signed(req.ay);
      az    = $signed(req.az);
      mag   = int_sqrt(longint'(ay * ay + az * az) << 16);
      ang_x = -vector_angle(ay * 256, az * 256);
      ang_y = -vector_angle(-ax * 256, longint'(mag));
    end else begin
      ang_x = $signed(req.tx);
      ang_y = $signed(req.ty);
    end
    px = axis_pulse(ang_x, held_x);
    py = axis_pulse(ang_y, held_y);
    held_x = px[12:0];
    held_y = py[12:0];
    res.pulse_x = held_x;
    res.pulse_y = held_y;
    res.angle_x = 17'(ang_x);
    res.angle_y = 17'(ang_y);
    res.x_ok    = px[13];
    res.y_ok    = py[13];
    return res;
  endfunction

  task automatic note_mismatch(input string what, input pulse_result_t want,
                               input pulse_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: exp px=%0d py=%0d ax=%0d ay=%0d ok=%b%b",
               $realtime, what, want.pulse_x, want.pulse_y, $signed(want.angle_x),
               $signed(want.angle_y), want.x_ok, want.y_ok);
      $display("    got px=%0d py=%0d ax=%0d ay=%0d ok=%b%b",
               got.pulse_x, got.pulse_y, $signed(got.angle_x), $signed(got.angle_y),
               got.x_ok, got.y_ok);
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_pulses_q.push_back(predict_pulses(offered_req));
        requests_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        tx_idle = !(requests_accepted >= 400 && requests_accepted < 520) &&
                  ($urandom_range(99) < IDLE_PCT);
        if (pending_requests_q.size() != 0 && !tx_idle) begin
          offered_req = pending_requests_q.pop_front();
          in_tdata  <= {6'b0, offered_req.ty, offered_req.tx, offered_req.az,
                        offered_req.ay, offered_req.ax};
          in_tuser  <= offered_req.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off, counted in cycles, so the block parks a
  // request and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_clock <= 0;
      hold_left  <= 0;
    end else begin
      hold_clock <= hold_clock + 1;
      if (hold_clock == HOLD_START) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Result monitor and receiver backpressure
  always @(posedge clk) begin
    pulse_result_t got;
    pulse_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.pulse_x = out_tdata[12:0];
        got.pulse_y = out_tdata[25:13];
        got.angle_x = out_tdata[42:26];
        got.angle_y = out_tdata[59:43];
        got.x_ok    = out_tuser[0];
        got.y_ok    = out_tuser[1];
        results_seen++;
        if (expected_pulses_q.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_pulses_q.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= (results_seen >= 400 && results_seen < 520) ||
                      ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic write_reg(input logic [tsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    case (idx)
      tsp_pkg::REG_PULSE_MIN:   cur_pulse_min   = data[11:0];
      tsp_pkg::REG_PULSE_SPAN:  cur_pulse_span  = data[11:0];
      tsp_pkg::REG_ANGLE_LIMIT: cur_angle_limit = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input int ax, input int ay, input int az);
    tilt_request_t req;
    req.cmd = tsp_pkg::CMD_ACCEL;
    req.ax  = 16'(ax);
    req.ay  = 16'(ay);
    req.az  = 16'(az);
    req.tx  = 17'($urandom);
    req.ty  = 17'($urandom);
    pending_requests_q.push_back(req);
  endtask

  task automatic queue_target(input int tx, input int ty);
    tilt_request_t req;
    req.cmd = tsp_pkg::CMD_TARGET;
    req.ax  = 16'($urandom);
    req.ay  = 16'($urandom);
    req.az  = 16'($urandom);
    req.tx  = 17'(tx);
    req.ty  = 17'(ty);
    pending_requests_q.push_back(req);
  endtask

  function automatic int edge_angle(input int lim);
    case ($urandom_range(3))
      0:       return lim;
      1:       return -lim;
      2:       return lim + 1;
      default: return -lim - 1;
    endcase
  endfunction

  function automatic int gravity_axis();
    int g;
    g = int'($urandom_range(12000, 20000));
    return $urandom_range(1) ? g : -g;
  endfunction

  function automatic int noise_axis();
    return int'($urandom_range(4000)) - 2000;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 32767;
      2:       return -32768;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // random mix of tilt samples and target pairs
  task automatic queue_random(input int unsigned count);
    int lim;
    int kind;
    int sel;
    lim = int'(cur_angle_limit);
    repeat (count) begin
      kind = int'($urandom_range(99));
      if (kind < 30) begin
        queue_sample(int'($urandom_range(65535)) - 32768,
                     int'($urandom_range(65535)) - 32768,
                     int'($urandom_range(65535)) - 32768);
      end else if (kind < 50) begin
        sel = int'($urandom_range(2));
        case (sel)
          0:       queue_sample(gravity_axis(), noise_axis(), noise_axis());
          1:       queue_sample(noise_axis(), gravity_axis(), noise_axis());
          default: queue_sample(noise_axis(), noise_axis(), gravity_axis());
        endcase
      end else if (kind < 60) begin
        queue_sample(int'($urandom_range(31)) - 16, int'($urandom_range(31)) - 16,
                     int'($urandom_range(31)) - 16);
      end else if (kind < 65) begin
        queue_sample(pick_extreme(), pick_extreme(), pick_extreme());
      end else if (kind < 85) begin
        queue_target(int'($urandom_range(2 * lim)) - lim, int'($urandom_range(2 * lim)) - lim);
      end else if (kind < 93) begin
        queue_target(edge_angle(lim), edge_angle(lim));
      end else begin
        queue_target(int'($urandom_range(131071)) - 65536,
                     int'($urandom_range(131071)) - 65536);
      end
    end
  endtask

  // wait until every request has been answered and the block is idle
  task automatic drain();
    @(negedge clk);
    while (pending_requests_q.size() != 0 || in_tvalid || expected_pulses_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Stimulus sequence
  initial begin
    cur_pulse_min   = tsp_pkg::PULSE_MIN_RST;
    cur_pulse_span  = tsp_pkg::PULSE_SPAN_RST;
    cur_angle_limit = tsp_pkg::ANGLE_LIMIT_RST;
    held_x = '0;
    held_y = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset defaults: zero vector, flat, upside down, axis and corner extremes
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 16384);
    queue_sample(0, 0, -16384);
    queue_sample(0, -1, -16384);
    queue_sample(0, 1, -16384);
    queue_sample(16384, 0, 16384);
    queue_sample(-16384, 0, 16384);
    queue_sample(32767, 0, 0);
    queue_sample(-32768, 0, 0);
    queue_sample(0, 32767, 0);
    queue_sample(0, -32768, 0);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    // targets at, just inside and beyond the limit, and 17-bit extremes
    queue_target(34560, -34560);
    queue_target(34561, -34561);
    queue_target(0, 0);
    queue_target(34559, -34559);
    queue_target(46080, -46080);
    queue_target(65535, -65536);
    queue_target(17280, -17280);
    drain();
    queue_random(100);
    drain();

    // widest mapping, lowest base pulse
    write_reg(tsp_pkg::REG_PULSE_MIN, 16'd0);
    write_reg(tsp_pkg::REG_PULSE_SPAN, 16'd4095);
    write_reg(tsp_pkg::REG_ANGLE_LIMIT, 16'd46080);
    queue_target(46080, -46080);
    queue_target(-46080, 46080);
    queue_sample(0, 0, -16384);
    queue_random(150);
    drain();

    // highest pulses, narrowest limit
    write_reg(tsp_pkg::REG_PULSE_MIN, 16'd4095);
    write_reg(tsp_pkg::REG_ANGLE_LIMIT, 16'd256);
    queue_target(256, -256);
    queue_target(257, -257);
    queue_random(150);
    drain();

    // zero limit and zero span
    write_reg(tsp_pkg::REG_PULSE_MIN, 16'd500);
    write_reg(tsp_pkg::REG_PULSE_SPAN, 16'd0);
    write_reg(tsp_pkg::REG_ANGLE_LIMIT, 16'd0);
    queue_target(0, 0);
    queue_target(1, -1);
    queue_target(-1, 0);
    queue_sample(0, 0, 16384);
    queue_sample(0, 0, 0);
    queue_random(40);
    drain();

    // zero span with a normal limit
    write_reg(tsp_pkg::REG_ANGLE_LIMIT, 16'd34560);
    queue_target(34560, -34560);
    queue_target(0, 100);
    queue_random(40);
    drain();

    // write to an unused index must change nothing
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_target(34560, 0);
    drain();

    // random settings; upper data bits of the 12-bit registers are junk
    repeat (4) begin
      write_reg(tsp_pkg::REG_PULSE_MIN, {4'($urandom), 12'($urandom_range(4095))});
      write_reg(tsp_pkg::REG_PULSE_SPAN, {4'($urandom), 12'($urandom_range(1, 4095))});
      write_reg(tsp_pkg::REG_ANGLE_LIMIT, 16'($urandom_range(256, 46080)));
      queue_random(90);
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_pulses_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
